// ===== rtl/core/sumd_frame_receiver_defines.svh =====
// Assertion macros used by the checker of the frame receiver.
// Every macro samples on i_clk and is held off while i_rst_n is low.
`ifndef SUMD_FRAME_RECEIVER_DEFINES_SVH
`define SUMD_FRAME_RECEIVER_DEFINES_SVH

// Condition in the same cycle
`define SUMD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Condition in the following cycle
`define SUMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

// ===== rtl/core/sumd_pkg.sv =====
package sumd_pkg;

    // Channel limit and the byte store it sizes
    localparam int MAX_CHANNELS  = 16;
    localparam int HEADER_BYTES  = 5;
    localparam int FRAME_STORE   = MAX_CHANNELS * 2 + HEADER_BYTES;
    localparam int STORE_AW      = $clog2(FRAME_STORE);
    localparam int CNT_W         = $clog2(MAX_CHANNELS + 1);

    // Frame layout
    localparam int FIRST_CH_BYTE = 3;
    localparam int POS_STATUS    = 1;
    localparam int POS_COUNT     = 2;
    localparam int POS_W         = 10;

    // Field widths
    localparam int BYTE_W        = 8;
    localparam int TIME_W        = 32;
    localparam int INDEX_W       = 4;
    localparam int VALUE_W       = 13;
    localparam int FRCH_W        = 5;
    localparam int VALUE_SHIFT   = 3;

    // Codes
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hA8;
    localparam logic [BYTE_W-1:0] STATUS_OK = 8'h01;
    localparam logic [TIME_W-1:0] GAP_RESET = 32'd4000;

endpackage

// ===== rtl/core/sumd_frame_receiver.sv =====
// Channel   Direction  Handshake              Word
// byte in   input      i_valid / o_stall      i_rx_byte, i_arrival_time_us
// result    output     o_valid / i_stall      o_channel_index, o_channel_value,
//                                             o_frame_channels, o_last
// config    input      i_cfg_valid / o_cfg_ready  i_cfg_data (gap timeout, us)
//
// A byte that does not close a frame leaves the receiver in S_IDLE.
// A closing byte with good status walks N channels (clamped) through S_RD_HI, S_RD_LO,
// S_CAP and S_OUT, holding in S_OUT while i_stall is high; the single byte-store read
// port is walked hi/lo per channel. A zero-channel frame goes to S_OUT for its one result.
// Reset is synchronous, active low; the gap timeout resets to 4000.
// o_stall is high while results are being produced and while a result waits.
module sumd_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_arrival_time_us,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_channel_index,
    output logic [12:0] o_channel_value,
    output logic [4:0]  o_frame_channels,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import sumd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD_HI = 5'b00010,
        S_RD_LO = 5'b00100,
        S_CAP   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [BYTE_W-1:0]     r_decl, n_decl;
    logic [TIME_W-1:0]     r_prev, n_prev;
    logic                  r_status, n_status;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic [BYTE_W-1:0]     r_hi, n_hi;
    logic [TIME_W-1:0]     r_gap;

    logic [BYTE_W-1:0]     r_mem [FRAME_STORE];
    logic [BYTE_W-1:0]     r_rd_data;

    logic                  w_in_acc;
    logic [TIME_W-1:0]     w_diff;
    logic [POS_W-1:0]      w_pos_eff;
    logic [POS_W-1:0]      w_pos_next;
    logic [BYTE_W-1:0]     w_decl_eff;
    logic [POS_W-1:0]      w_frame_len;
    logic [CNT_W-1:0]      w_clamp;
    logic                  w_we;
    logic [STORE_AW-1:0]   w_base;
    logic [STORE_AW-1:0]   w_ra;
    logic                  w_last;

    assign w_in_acc    = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Gap check: wrapping difference against the timeout
    assign w_diff     = i_arrival_time_us - r_prev;
    assign w_pos_eff  = (w_diff > r_gap) ? '0 : r_pos;
    assign w_pos_next = w_pos_eff + POS_W'(1);
    assign w_decl_eff = (w_pos_eff == POS_W'(POS_COUNT)) ? i_rx_byte : r_decl;
    assign w_frame_len = POS_W'({w_decl_eff, 1'b0}) + POS_W'(HEADER_BYTES);
    assign w_clamp    = (w_decl_eff > BYTE_W'(MAX_CHANNELS)) ?
                        CNT_W'(MAX_CHANNELS) : CNT_W'(w_decl_eff);

    // Store read address: hi byte, then lo byte of the current channel
    assign w_base = STORE_AW'(FIRST_CH_BYTE) + (STORE_AW'(r_idx) << 1);
    assign w_ra   = (r_state == S_RD_LO) ? (w_base + STORE_AW'(1)) : w_base;

    assign w_last = (r_count == '0) || (CNT_W'(r_idx + 1'b1) == r_count);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_decl   = r_decl;
        n_prev   = r_prev;
        n_status = r_status;
        n_idx    = r_idx;
        n_count  = r_count;
        n_value  = r_value;
        n_hi     = r_hi;
        w_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_prev = i_arrival_time_us;
                    if (w_pos_eff == '0 && i_rx_byte != SYNC_BYTE) begin
                        n_pos = '0;
                    end else begin
                        w_we   = (w_pos_eff < POS_W'(FRAME_STORE));
                        n_decl = w_decl_eff;
                        if (w_pos_eff == POS_W'(POS_STATUS)) begin
                            n_status = (i_rx_byte == STATUS_OK);
                        end
                        if (w_pos_next == w_frame_len) begin
                            n_pos = '0;
                            if (r_status) begin
                                n_count = w_clamp;
                                n_idx   = '0;
                                if (w_clamp == '0) begin
                                    n_value = '0;
                                    n_state = S_OUT;
                                end else begin
                                    n_state = S_RD_HI;
                                end
                            end
                        end else begin
                            n_pos = w_pos_next;
                        end
                    end
                end
            end
            S_RD_HI: begin
                n_state = S_RD_LO;
            end
            S_RD_LO: begin
                n_hi    = r_rd_data;
                n_state = S_CAP;
            end
            S_CAP: begin
                n_value = VALUE_W'({r_hi, r_rd_data} >> VALUE_SHIFT);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD_HI;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_decl   <= '0;
            r_prev   <= '0;
            r_status <= 1'b0;
            r_idx    <= '0;
            r_count  <= '0;
            r_gap    <= GAP_RESET;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_decl   <= n_decl;
            r_prev   <= n_prev;
            r_status <= n_status;
            r_idx    <= n_idx;
            r_count  <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_gap <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_hi    <= n_hi;
    end

    // Frame byte store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[STORE_AW'(w_pos_eff)] <= i_rx_byte;
        end
        r_rd_data <= r_mem[w_ra];
    end

    assign o_valid          = (r_state == S_OUT);
    assign o_channel_index  = INDEX_W'(r_idx);
    assign o_channel_value  = r_value;
    assign o_frame_channels = FRCH_W'(r_count);
    assign o_last           = w_last;

endmodule

// ===== rtl/core/sumd_frame_receiver_checker.sv =====
`include "sumd_frame_receiver_defines.svh"

module sumd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [3:0]  o_channel_index,
    input logic [12:0] o_channel_value,
    input logic [4:0]  o_frame_channels,
    input logic        o_last
);

    // A stalled result word holds its value
    `SUMD_ASSERT_NEXT(a_hold_value, o_valid && i_stall, o_valid && $stable(o_channel_value))

    // No byte is taken while a result is pending
    `SUMD_ASSERT_SAME(a_busy_stall, o_valid, o_stall)

    // Index stays below the frame's channel count
    `SUMD_ASSERT_SAME(a_index_range, o_valid && o_frame_channels != 5'd0,
        {1'b0, o_channel_index} < o_frame_channels)

    // Last flag marks the final channel
    `SUMD_ASSERT_SAME(a_last_pos, o_valid && o_frame_channels != 5'd0,
        o_last == (({1'b0, o_channel_index} + 5'd1) == o_frame_channels))

endmodule

bind sumd_frame_receiver sumd_chk u_sumd_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_channel_index  (o_channel_index),
    .o_channel_value  (o_channel_value),
    .o_frame_channels (o_frame_channels),
    .o_last           (o_last)
);

// ===== tb/sumd_frame_receiver_tb.sv =====
`timescale 1ns / 1ps

module sumd_frame_receiver_tb;
    import sumd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [INDEX_W-1:0] ch_index;
        logic [VALUE_W-1:0] ch_value;
        logic [FRCH_W-1:0]  frame_ch;
        logic               last_flag;
    } t_channel_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_rx_byte;
    logic [31:0] i_arrival_time_us;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_channel_index;
    logic [12:0] o_channel_value;
    logic [4:0]  o_frame_channels;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    sumd_frame_receiver i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_rx_byte         (i_rx_byte),
        .i_arrival_time_us (i_arrival_time_us),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_channel_index   (o_channel_index),
        .o_channel_value   (o_channel_value),
        .o_frame_channels  (o_frame_channels),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Frame assembly state mirrored on the testbench side
    logic [BYTE_W-1:0] frame_copy [FRAME_STORE];
    logic [POS_W-1:0]  frame_pos = '0;
    logic [7:0]        declared_count = '0;
    logic [TIME_W-1:0] last_arrival = '0;
    logic [TIME_W-1:0] gap_limit_us = GAP_RESET;

    t_channel_word pending_channels [$];
    int            n_errors = 0;
    int            cycle_count = 0;

    // Traffic shaping knobs
    int          stall_pct = 0;
    int          sender_gap_max = 0;
    int          burst_left = 0;
    logic [31:0] now_us = '0;

    initial begin
        for (int k = 0; k < FRAME_STORE; k++) frame_copy[STORE_AW'(k)] = '0;
    end

    // Channel results that one accepted byte gives
    function automatic void predict_sumd_byte(input logic [7:0] rx, input logic [31:0] t);
        logic [31:0]   elapsed;
        int            n_ch;
        logic [15:0]   word;
        t_channel_word r;
        elapsed = t - last_arrival;
        if (elapsed > gap_limit_us) frame_pos = '0;
        last_arrival = t;
        if (frame_pos == '0 && rx != SYNC_BYTE) return;
        if (frame_pos == POS_W'(POS_COUNT)) declared_count = rx;
        if (frame_pos < POS_W'(FRAME_STORE)) frame_copy[STORE_AW'(frame_pos)] = rx;
        frame_pos = frame_pos + 1'b1;
        if (frame_pos != {declared_count, 1'b0} + 10'd5) return;
        frame_pos = '0;
        if (frame_copy[STORE_AW'(POS_STATUS)] != STATUS_OK) return;
        n_ch = (declared_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(declared_count);
        if (n_ch == 0) begin
            r = '0;
            r.last_flag = 1'b1;
            pending_channels.push_back(r);
            return;
        end
        for (int ch = 0; ch < n_ch; ch++) begin
            word = {frame_copy[STORE_AW'(FIRST_CH_BYTE + 2 * ch)],
                    frame_copy[STORE_AW'(FIRST_CH_BYTE + 1 + 2 * ch)]};
            r.ch_index  = INDEX_W'(ch);
            r.ch_value  = VALUE_W'(word >> VALUE_SHIFT);
            r.frame_ch  = FRCH_W'(n_ch);
            r.last_flag = (ch == n_ch - 1);
            pending_channels.push_back(r);
        end
    endfunction

    // Arrival time of the next byte; restart forces a gap past the timeout if it is below 32'hFFFF_0000
    function automatic logic [31:0] next_time(input bit restart);
        logic [31:0] delta;
        if (restart && gap_limit_us < 32'hFFFF_0000) begin
            delta = gap_limit_us + 1;
            if ($urandom_range(0, 1)) delta = delta + $urandom_range(0, 5000);
        end else if ($urandom_range(0, 9) == 0) begin
            delta = gap_limit_us;
        end else begin
            delta = $urandom_range(0, (gap_limit_us < 200) ? gap_limit_us : 200);
        end
        now_us = now_us + delta;
        return now_us;
    endfunction

    // Send one byte word; bursts end with a random idle gap when sender_gap_max is nonzero
    task automatic send_byte(input logic [7:0] rx, input logic [31:0] t);
        bit taken;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        i_valid           <= 1'b1;
        i_rx_byte         <= rx;
        i_arrival_time_us <= t;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            if (taken) predict_sumd_byte(rx, t);
            @(posedge i_clk);
        end while (!taken);
        burst_left--;
        if (burst_left == 0 && sender_gap_max != 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, sender_gap_max)) @(posedge i_clk);
        end
    endtask

    // Whole frame; cut_at < 0 keeps it intact, else a timeout hits that byte
    task automatic send_frame(input logic [7:0] status, input int n_ch, input int cut_at);
        int          total;
        logic [7:0]  rx;
        total = n_ch * 2 + HEADER_BYTES;
        for (int k = 0; k < total; k++) begin
            case (k)
                0: rx = SYNC_BYTE;
                POS_STATUS: rx = status;
                POS_COUNT: rx = n_ch[7:0];
                default: rx = 8'($urandom_range(0, 255));
            endcase
            send_byte(rx, next_time(k == cut_at));
        end
    endtask

    // Stop sending and let every pending channel come out
    task automatic wait_frames_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_channels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gap_timeout(input logic [31:0] gap);
        bit ready_seen;
        wait_frames_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= gap;
        do begin
            @(negedge i_clk);
            ready_seen = o_cfg_ready;
            @(posedge i_clk);
        end while (!ready_seen);
        gap_limit_us = gap;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly good frames, with noise, bad status, long and cut frames mixed in
    task automatic run_random_frames(input int n_bytes);
        int         sent;
        int         n_ch;
        int         cut;
        int         pick;
        logic [7:0] status;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)),
                              next_time($urandom_range(0, 4) == 0));
            end else begin
                pick = $urandom_range(0, 9);
                if (pick == 0) n_ch = $urandom_range(MAX_CHANNELS + 1, MAX_CHANNELS + 8);
                else if (pick < 3) n_ch = MAX_CHANNELS;
                else n_ch = $urandom_range(0, MAX_CHANNELS - 1);
                status = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : STATUS_OK;
                cut = ($urandom_range(0, 9) == 0) ?
                      int'($urandom_range(0, n_ch * 2 + HEADER_BYTES - 1)) : -1;
                send_frame(status, n_ch, cut);
                sent += n_ch * 2 + HEADER_BYTES;
            end
        end
    endtask

    task automatic test_zero_channel_frame();
        send_frame(STATUS_OK, 0, -1);
    endtask

    // Full-scale and zero channel words
    task automatic test_channel_extremes();
        send_byte(SYNC_BYTE, next_time(1'b0));
        send_byte(STATUS_OK, next_time(1'b0));
        send_byte(8'd2, next_time(1'b0));
        send_byte(8'hFF, next_time(1'b0));
        send_byte(8'hFF, next_time(1'b0));
        send_byte(8'h00, next_time(1'b0));
        send_byte(8'h07, next_time(1'b0));
        send_byte(8'h5A, next_time(1'b0));
        send_byte(8'hA5, next_time(1'b0));
    endtask

    task automatic test_bad_status();
        send_frame(8'h81, 0, -1);
    endtask

    task automatic test_noise_before_sync();
        send_byte(8'h00, next_time(1'b0));
        send_byte(8'hFF, next_time(1'b1));
    endtask

    // Timeout in the middle of a frame, then a fresh frame
    task automatic test_gap_restart();
        send_byte(SYNC_BYTE, next_time(1'b0));
        send_byte(STATUS_OK, next_time(1'b0));
        send_frame(STATUS_OK, 0, 0);
    endtask

    task automatic test_default_gap_random();
        stall_pct = 30;
        sender_gap_max = 6;
        run_random_frames(110);
    endtask

    task automatic test_zero_gap();
        write_gap_timeout(32'd0);
        stall_pct = 70;
        sender_gap_max = 3;
        run_random_frames(40);
    endtask

    // Widest timeout with the timestamp wrapping through zero
    task automatic test_max_gap();
        write_gap_timeout(32'hFFFF_FFFF);
        stall_pct = 0;
        sender_gap_max = 0;
        now_us = 32'hFFFF_FF00;
        run_random_frames(50);
    endtask

    task automatic test_mid_gap();
        write_gap_timeout($urandom_range(1, 500));
        stall_pct = 30;
        sender_gap_max = 8;
        run_random_frames(45);
        write_gap_timeout(GAP_RESET);
        stall_pct = 50;
        sender_gap_max = 2;
        run_random_frames(25);
    endtask

    // Result side stall pattern
    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each accepted result word with the oldest expectation
    always @(negedge i_clk) begin
        t_channel_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_channels.size() == 0) begin
                $error("unexpected result: index %0d value %0d", o_channel_index,
                       o_channel_value);
                n_errors++;
            end else begin
                want = pending_channels.pop_front();
                if (o_channel_index !== want.ch_index) begin
                    $error("channel_index expected %0d got %0d", want.ch_index,
                           o_channel_index);
                    n_errors++;
                end
                if (o_channel_value !== want.ch_value) begin
                    $error("channel_value expected %0d got %0d", want.ch_value,
                           o_channel_value);
                    n_errors++;
                end
                if (o_frame_channels !== want.frame_ch) begin
                    $error("frame_channels expected %0d got %0d", want.frame_ch,
                           o_frame_channels);
                    n_errors++;
                end
                if (o_last !== want.last_flag) begin
                    $error("last expected %0d got %0d", want.last_flag, o_last);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL sumd_frame_receiver");
        $finish;
    end

    initial begin
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_rx_byte         <= '0;
        i_arrival_time_us <= '0;
        i_stall           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_data        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_channel_frame();
        test_channel_extremes();
        test_bad_status();
        test_noise_before_sync();
        test_gap_restart();
        test_default_gap_random();
        test_zero_gap();
        test_max_gap();
        test_mid_gap();
        wait_frames_drained();

        if (n_errors == 0) begin
            $display("PASS sumd_frame_receiver");
        end else begin
            $display("FAIL sumd_frame_receiver");
        end
        $finish;
    end

endmodule
